// ===== rtl/avs_pkg.sv =====
// Shared types, codes and constants of the A/V sync frame pacer.
// No dependencies; every other file imports this package.
package avs_pkg;

	// Width of the frame/drift counters kept internally
	localparam int CNT_W = 32;

	localparam int TS_W      = 62;
	localparam int WIDE_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 40;

	// Item action codes
	localparam logic [1:0] ACT_RESTART = 2'd0;
	localparam logic [1:0] ACT_AUDIO   = 2'd1;
	localparam logic [1:0] ACT_FRAME   = 2'd2;

	// Verdict codes
	localparam logic [1:0] VERDICT_NONE = 2'd0;
	localparam logic [1:0] VERDICT_SHOW = 2'd1;
	localparam logic [1:0] VERDICT_WAIT = 2'd2;
	localparam logic [1:0] VERDICT_DROP = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HAVE_AUDIO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESYNC       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DROP         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DROP_RUN = 3'd4;

	// Configuration reset values
	localparam logic [31:0] MAX_SLEEP_RST    = 32'd250000000;
	localparam logic [39:0] RESYNC_RST       = 40'd1000000000;
	localparam logic [31:0] DROP_RST         = 32'd50000000;
	localparam logic [7:0]  MAX_DROP_RUN_RST = 8'd4;

	// Drift statistics reset values: peak -(2^63-1), floor 2^63-1
	localparam logic [WIDE_W-1:0] PEAK_RST  = {1'b1, {(WIDE_W-2){1'b0}}, 1'b1};
	localparam logic [WIDE_W-1:0] FLOOR_RST = {1'b0, {(WIDE_W-1){1'b1}}};

	typedef struct packed {
		logic        audio_en;
		logic [31:0] sleep_cap;
		logic [39:0] resync_lim;
		logic [31:0] drop_ns;
		logic [7:0]  drop_cap;
	} cfg_t;

	// Request held in the input stage, with the two time differences
	typedef struct packed {
		logic [1:0]        action;
		logic [TS_W-1:0]   pts_ns;
		logic [WIDE_W-1:0] pts_minus_now;
		logic [WIDE_W-1:0] now_minus_pts;
	} s1_t;

	typedef struct packed {
		logic [1:0]        verdict;
		logic [31:0]       wait_ns;
		logic [WIDE_W-1:0] recent_drift;
		logic [31:0]       shown_count;
		logic [31:0]       dropped_count;
		logic [31:0]       resync_count;
		logic [WIDE_W-1:0] drift_total_ns;
		logic [31:0]       drift_samples;
		logic [WIDE_W-1:0] drift_peak_ns;
		logic [WIDE_W-1:0] drift_floor_ns;
	} result_t;

endpackage

// ===== rtl/avs_if.sv =====
// Valid/ready channel interfaces for pacer requests and results.
// Depends on avs_pkg for field widths.
interface avs_in_if;
	import avs_pkg::*;
	logic            valid;
	logic            ready;
	logic [1:0]      action;
	logic [TS_W-1:0] pts_ns;
	logic [TS_W-1:0] now_ns;

	modport source (output valid, output action, output pts_ns, output now_ns, input ready);
	modport sink   (input valid, input action, input pts_ns, input now_ns, output ready);
endinterface

interface avs_out_if;
	import avs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               verdict;
	logic [31:0]              wait_ns;
	logic signed [WIDE_W-1:0] recent_drift;
	logic [31:0]              shown_count;
	logic [31:0]              dropped_count;
	logic [31:0]              resync_count;
	logic signed [WIDE_W-1:0] drift_total_ns;
	logic [31:0]              drift_samples;
	logic signed [WIDE_W-1:0] drift_peak_ns;
	logic signed [WIDE_W-1:0] drift_floor_ns;

	modport source (output valid, output verdict, output wait_ns, output recent_drift,
		output shown_count, output dropped_count, output resync_count,
		output drift_total_ns, output drift_samples, output drift_peak_ns,
		output drift_floor_ns, input ready);
	modport sink (input valid, input verdict, input wait_ns, input recent_drift,
		input shown_count, input dropped_count, input resync_count,
		input drift_total_ns, input drift_samples, input drift_peak_ns,
		input drift_floor_ns, output ready);
endinterface

// ===== rtl/av_sync_frame_pacer_unit.sv =====
// A/V sync frame pacer, top level. A request is captured in the input
// register, then its result in the result register once that register
// is free. Throughput: one request per cycle while the result channel is
// ready; the state update per request is a single pass between the two
// registers. Reset clears all pacing state and statistics and returns
// registers to defaults; restart clears pacing state and statistics only.
module av_sync_frame_pacer_unit
	import avs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	avs_in_if.sink               item_in,
	avs_out_if.source            result_out
);

	cfg_t    cfg;
	logic    s1_vld;
	s1_t     s1_item;
	logic    out_free;
	logic    fire;
	result_t res;

	// A held request is processed when the result register can take it
	assign fire = s1_vld && out_free;

	avs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	avs_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_in (item_in),
		.take    (fire),
		.vld     (s1_vld),
		.item    (s1_item)
	);

	avs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (s1_item),
		.res    (res)
	);

	avs_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire),
		.res        (res),
		.free       (out_free),
		.result_out (result_out)
	);

endmodule

// ===== rtl/avs_cfg_regs.sv =====
// Configuration register file of the pacer: plain indexed write port.
// Depends on avs_pkg.
module avs_cfg_regs
	import avs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.audio_en   <= 1'b0;
			cfg_q.sleep_cap  <= MAX_SLEEP_RST;
			cfg_q.resync_lim <= RESYNC_RST;
			cfg_q.drop_ns    <= DROP_RST;
			cfg_q.drop_cap   <= MAX_DROP_RUN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HAVE_AUDIO:   cfg_q.audio_en   <= cfg_data[0];
				CFG_MAX_SLEEP:    cfg_q.sleep_cap  <= cfg_data[31:0];
				CFG_RESYNC:       cfg_q.resync_lim <= cfg_data[39:0];
				CFG_DROP:         cfg_q.drop_ns    <= cfg_data[31:0];
				CFG_MAX_DROP_RUN: cfg_q.drop_cap   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/avs_in_stage.sv =====
// Input register of the pacer: captures a request and its time differences.
// Depends on avs_pkg and avs_in_if.
module avs_in_stage
	import avs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	avs_in_if.sink    item_in,
	input  logic      take,
	output logic      vld,
	output s1_t       item
);

	logic vld_s1;
	s1_t  item_s1;
	logic accept;

	// Free when empty or when the held request moves on this cycle
	assign item_in.ready = !vld_s1 || take;
	assign accept        = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	// Payload, with pts-now precomputed in both directions
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action        <= item_in.action;
			item_s1.pts_ns        <= item_in.pts_ns;
			item_s1.pts_minus_now <= {2'b00, item_in.pts_ns} - {2'b00, item_in.now_ns};
			item_s1.now_minus_pts <= {2'b00, item_in.now_ns} - {2'b00, item_in.pts_ns};
		end
	end

	assign vld  = vld_s1;
	assign item = item_s1;

endmodule

// ===== rtl/avs_core.sv =====
// Pacer state and per-request decision: master clock, drift, verdict, stats.
// Depends on avs_pkg.
module avs_core
	import avs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    fire,
	input  s1_t     item,
	output result_t res
);

	// Wall anchor and media anchor are kept only as media - wall;
	// the audio master time pos + offset is kept precomputed.
	typedef struct packed {
		logic              running;
		logic [WIDE_W-1:0] anchor_diff;
		logic              aud_vld;
		logic [TS_W-1:0]   aud_pos;
		logic [WIDE_W-1:0] aud_off;
		logic [WIDE_W-1:0] aud_master;
		logic [7:0]        streak;
		logic [CNT_W-1:0]  shown;
		logic [CNT_W-1:0]  dropped;
		logic [CNT_W-1:0]  resyncs;
		logic [WIDE_W-1:0] acc;
		logic [CNT_W-1:0]  samples;
		logic [WIDE_W-1:0] peak;
		logic [WIDE_W-1:0] floor_v;
		logic [WIDE_W-1:0] recent;
	} st_t;

	localparam st_t ST_RST = '{
		running:     1'b0,
		anchor_diff: '0,
		aud_vld:     1'b0,
		aud_pos:     '0,
		aud_off:     '0,
		aud_master:  '1,
		streak:      '0,
		shown:       '0,
		dropped:     '0,
		resyncs:     '0,
		acc:         '0,
		samples:     '0,
		peak:        PEAK_RST,
		floor_v:     FLOOR_RST,
		recent:      '0
	};

	st_t st_q;
	st_t st_d;

	logic [WIDE_W-1:0] pts64;
	logic              amaster;
	logic [WIDE_W-1:0] drift;
	logic [WIDE_W-1:0] late;
	logic [WIDE_W-1:0] nd;
	logic              ahead;
	logic              resync_hit;
	logic              drop_hit;
	logic              first;
	logic              do_resync;
	logic              do_drop;
	logic              do_show;
	logic              do_note;
	logic              is_frame;
	logic [1:0]        verdict;
	logic [31:0]       sleep;

	assign pts64   = {2'b00, item.pts_ns};
	assign amaster = cfg.audio_en && st_q.aud_vld;

	// Drift and lateness, each one add from stored terms
	assign drift = amaster ? (pts64 - st_q.aud_master)
		: (item.pts_minus_now - st_q.anchor_diff);
	assign late  = amaster ? (st_q.aud_master - pts64)
		: (item.now_minus_pts + st_q.anchor_diff);

	assign ahead      = $signed(drift) > $signed(WIDE_W'(0));
	assign resync_hit = $signed(WIDE_W'(cfg.resync_lim)) < $signed(late);
	assign drop_hit   = ($signed(WIDE_W'(cfg.drop_ns)) < $signed(late))
		&& (st_q.streak < cfg.drop_cap);

	// Frame decision
	assign is_frame  = (item.action == ACT_FRAME);
	assign first     = is_frame && !st_q.running;
	assign do_resync = is_frame && st_q.running && !ahead && resync_hit;
	assign do_drop   = is_frame && st_q.running && !ahead && !resync_hit && drop_hit;
	assign do_show   = first || do_resync
		|| (is_frame && st_q.running && !ahead && !resync_hit && !drop_hit);
	assign do_note   = first || (is_frame && st_q.running && !ahead);
	assign nd        = first ? '0 : drift;

	// Verdict and clamped wait time
	always_comb begin
		sleep   = 32'd0;
		verdict = VERDICT_NONE;
		if (is_frame && st_q.running && ahead) begin
			verdict = VERDICT_WAIT;
			sleep   = (drift > WIDE_W'(cfg.sleep_cap)) ? cfg.sleep_cap : drift[31:0];
		end else if (do_drop) begin
			verdict = VERDICT_DROP;
		end else if (do_show) begin
			verdict = VERDICT_SHOW;
		end
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (item.action)
			ACT_RESTART: begin
				st_d = ST_RST;
			end
			ACT_AUDIO: begin
				if (!st_q.aud_vld || (item.pts_ns > st_q.aud_pos)) begin
					st_d.aud_vld    = 1'b1;
					st_d.aud_pos    = item.pts_ns;
					st_d.aud_master = pts64 + st_q.aud_off;
				end
			end
			ACT_FRAME: begin
				if (first) begin
					st_d.running = 1'b1;
				end
				// Re-anchor the master clock
				if (first || (do_resync && !amaster)) begin
					st_d.anchor_diff = item.pts_minus_now;
				end
				if ((first || do_resync) && amaster) begin
					st_d.aud_off    = pts64 - {2'b00, st_q.aud_pos};
					st_d.aud_master = pts64;
				end
				// Drift statistics
				if (do_note) begin
					st_d.recent  = nd;
					st_d.acc     = st_q.acc + nd;
					st_d.samples = st_q.samples + CNT_W'(1);
					if ($signed(st_q.peak) < $signed(nd)) begin
						st_d.peak = nd;
					end
					if ($signed(nd) < $signed(st_q.floor_v)) begin
						st_d.floor_v = nd;
					end
				end
				// Drop run and counters
				if (do_drop) begin
					st_d.streak  = st_q.streak + 8'd1;
					st_d.dropped = st_q.dropped + CNT_W'(1);
				end else if (do_show && !first) begin
					st_d.streak = 8'd0;
				end
				if (do_resync) begin
					st_d.resyncs = st_q.resyncs + CNT_W'(1);
				end
				if (do_show) begin
					st_d.shown = st_q.shown + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RST;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	// Result reflects the statistics after this request
	always_comb begin
		res.verdict        = verdict;
		res.wait_ns        = sleep;
		res.recent_drift   = st_d.recent;
		res.shown_count    = 32'(st_d.shown);
		res.dropped_count  = 32'(st_d.dropped);
		res.resync_count   = 32'(st_d.resyncs);
		res.drift_total_ns = st_d.acc;
		res.drift_samples  = 32'(st_d.samples);
		res.drift_peak_ns  = st_d.peak;
		res.drift_floor_ns = st_d.floor_v;
	end

endmodule

// ===== rtl/avs_out_reg.sv =====
// Result register of the pacer driving the result channel.
// Depends on avs_pkg and avs_out_if.
module avs_out_reg
	import avs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  result_t    res,
	output logic       free,
	avs_out_if.source  result_out
);

	logic    vld_q;
	result_t res_q;

	assign free = !vld_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (result_out.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result_out.valid          = vld_q;
	assign result_out.verdict        = res_q.verdict;
	assign result_out.wait_ns        = res_q.wait_ns;
	assign result_out.recent_drift   = res_q.recent_drift;
	assign result_out.shown_count    = res_q.shown_count;
	assign result_out.dropped_count  = res_q.dropped_count;
	assign result_out.resync_count   = res_q.resync_count;
	assign result_out.drift_total_ns = res_q.drift_total_ns;
	assign result_out.drift_samples  = res_q.drift_samples;
	assign result_out.drift_peak_ns  = res_q.drift_peak_ns;
	assign result_out.drift_floor_ns = res_q.drift_floor_ns;

endmodule
